// ===== rtl/core/hfd_pkg.sv =====
// Shared types, widths and helper functions for the Hamming frame decoder.
package hfd_pkg;

    localparam int BLOCK_W     = 63;
    localparam int DATA_W      = 57;
    localparam int CNT_W       = 6;
    localparam int SYN_W       = 6;
    localparam int LEN_W       = 20;
    localparam int DBITS_W     = 6;
    localparam int PBITS_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DATA_BITS   = 2'd0,
        REG_PARITY_BITS = 2'd1,
        REG_ORIG_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [DBITS_W-1:0] data_bits;
        logic [PBITS_W-1:0] parity_bits;
        logic [LEN_W-1:0]   original_length;
    } hfd_cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic [SYN_W-1:0]  syndrome;
        logic              corrected;
        logic              uncorrectable;
        logic              last;
    } hfd_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic [SYN_W-1:0]  syndrome;
        logic              corrected;
        logic              uncorrectable;
        logic              frame_end;
        logic              frame_valid;
        logic [LEN_W-1:0]  corrected_blocks;
        logic [LEN_W-1:0]  uncorrectable_blocks;
    } hfd_result_t;

    function automatic bit is_pow2(int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // data bit that code position p lands in: positions before p minus the
    // parity positions up to p
    function automatic int data_index(int p);
        return p - $clog2(p + 1) - 1;
    endfunction

endpackage

// ===== rtl/core/hamming_frame_decoder.sv =====
// Top level of the Hamming frame decoder: configuration registers and channel wiring.
//
// Single-error-correcting Hamming decoder with frame bookkeeping. Each
// transaction on the input channel carries one received block (code position
// p in bit p-1, n = data_bits + parity_bits positions, clamped to
// MAX_BLOCK_BITS). The front end forms the even-parity syndrome, flips the
// addressed bit when the syndrome lies inside the block (corrected) or flags
// it when it points beyond the block (uncorrectable), and packs the
// non-power-of-two positions into data_out. The back end truncates each
// block's data so the frame never delivers more than original_length bits,
// keeps saturating per-frame counts of corrected and uncorrectable blocks,
// and on a block marked last_block reports frame_end together with
// frame_valid (delivered bits reached original_length), then clears its frame
// state. One block is taken per clock cycle while in_stall is low; a result
// passes through the queue and then the output register before it is
// presented. The front end is combinational XOR trees and fixed bit packing
// that write a two-entry queue at the accepting edge; the back end pops the
// queue into a single output register. in_stall rises only when the queue is
// full, i.e. after out_stall has held the output. Configuration writes (index
// 0 data_bits, 1 parity_bits, 2 original_length, others ignored) take effect
// at the next edge and are meant for idle periods.
module hamming_frame_decoder
    import hfd_pkg::*;
#(
    parameter int MAX_BLOCK_BITS   = 63,
    parameter int FRAME_COUNT_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BLOCK_W-1:0]    block_bits,
    input  logic                  last_block,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_W-1:0]     data_out,
    output logic [CNT_W-1:0]      data_count,
    output logic [SYN_W-1:0]      syndrome,
    output logic                  corrected,
    output logic                  uncorrectable,
    output logic                  frame_end,
    output logic                  frame_valid,
    output logic [LEN_W-1:0]      corrected_blocks,
    output logic [LEN_W-1:0]      uncorrectable_blocks
);

    hfd_cfg_t    cfg_reg, cfg_next;
    hfd_item_t   front_item;
    hfd_item_t   head_item;
    hfd_result_t result;
    logic        push;
    logic        q_full;
    logic        head_valid;
    logic        pop;

    // Configuration registers: update only the addressed field, ignore
    // indexes beyond the register list.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DATA_BITS:   cfg_next.data_bits       = cfg_data[DBITS_W-1:0];
                REG_PARITY_BITS: cfg_next.parity_bits     = cfg_data[PBITS_W-1:0];
                REG_ORIG_LENGTH: cfg_next.original_length = cfg_data[LEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_bits       <= DBITS_W'(4);
            cfg_reg.parity_bits     <= PBITS_W'(3);
            cfg_reg.original_length <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept a transaction whenever the queue has room.
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    hfd_front #(
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_front (
        .cfg        (cfg_reg),
        .block_bits (block_bits),
        .last_block (last_block),
        .item       (front_item)
    );

    hfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    hfd_back #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .original_length (cfg_reg.original_length),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .result          (result)
    );

    // Unpack the held result onto the output fields.
    assign data_out             = result.data;
    assign data_count           = result.count;
    assign syndrome             = result.syndrome;
    assign corrected            = result.corrected;
    assign uncorrectable        = result.uncorrectable;
    assign frame_end            = result.frame_end;
    assign frame_valid          = result.frame_valid;
    assign corrected_blocks     = result.corrected_blocks;
    assign uncorrectable_blocks = result.uncorrectable_blocks;

endmodule

// ===== rtl/core/hfd_front.sv =====
// Front end: syndrome, single-bit correction and data-bit extraction of one block.
module hfd_front
    import hfd_pkg::*;
#(
    parameter int MAX_BLOCK_BITS = 63
)
(
    input  hfd_cfg_t           cfg,
    input  logic [BLOCK_W-1:0] block_bits,
    input  logic               last_block,
    output hfd_item_t          item
);

    logic [CNT_W:0]       n_sum;
    logic [CNT_W-1:0]     n;
    logic [BLOCK_W-1:0]   masked;
    logic [BLOCK_W-1:0]   fixed;
    logic [SYN_W-1:0]     syn;
    logic                 par;
    logic                 corr;
    logic                 unc;
    logic [DATA_W-1:0]    data;
    logic [CNT_W-1:0]     pow_cnt;

    always_comb
    begin
        n_sum = (CNT_W+1)'(cfg.data_bits) + (CNT_W+1)'(cfg.parity_bits);
        n     = (n_sum > (CNT_W+1)'(MAX_BLOCK_BITS)) ? CNT_W'(MAX_BLOCK_BITS)
                                                      : n_sum[CNT_W-1:0];

        // drop everything above the block length
        for (int p = 1; p <= BLOCK_W; p++)
        begin
            masked[p-1] = block_bits[p-1] & (CNT_W'(p) <= n);
        end

        // even parity per check bit; unused check bits stay zero
        for (int k = 0; k < SYN_W; k++)
        begin
            par = 1'b0;
            for (int p = 1; p <= BLOCK_W; p++)
            begin
                if ((p & (1 << k)) != 0)
                begin
                    par = par ^ masked[p-1];
                end
            end
            syn[k] = par & (PBITS_W'(k) < cfg.parity_bits);
        end

        corr = (syn != '0) && (syn <= n);
        unc  = (syn != '0) && (syn > n);

        for (int p = 1; p <= BLOCK_W; p++)
        begin
            fixed[p-1] = masked[p-1] ^ (corr && (syn == SYN_W'(p)));
        end

        data = '0;
        for (int p = 1; p <= BLOCK_W; p++)
        begin
            if (!is_pow2(p))
            begin
                data[data_index(p)] = fixed[p-1];
            end
        end

        pow_cnt = '0;
        for (int k = 0; k < SYN_W; k++)
        begin
            if (n >= CNT_W'(1 << k))
            begin
                pow_cnt = pow_cnt + CNT_W'(1);
            end
        end

        item.data          = data;
        item.count         = n - pow_cnt;
        item.syndrome      = syn;
        item.corrected     = corr;
        item.uncorrectable = unc;
        item.last          = last_block;
    end

endmodule

// ===== rtl/core/hfd_queue.sv =====
// Two-entry queue that decouples the block front end from the frame back end.
module hfd_queue
    import hfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hfd_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output hfd_item_t head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    hfd_item_t        store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign head_valid = (occ_reg != '0);
    assign head_item  = store_reg[rd_ptr_reg];

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_occ_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("queue occupancy did not follow a lone push");

endmodule

// ===== rtl/core/hfd_back.sv =====
// Back end: frame truncation, saturating counters and the output register.
module hfd_back
    import hfd_pkg::*;
#(
    parameter int FRAME_COUNT_BITS = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] original_length,
    input  logic             head_valid,
    input  hfd_item_t        head_item,
    output logic             pop,
    input  logic             out_stall,
    output logic             out_valid,
    output hfd_result_t      result
);

    localparam int WIDE_W = (FRAME_COUNT_BITS > LEN_W) ? FRAME_COUNT_BITS : LEN_W;

    logic [LEN_W-1:0]            delivered_reg, delivered_next;
    logic [FRAME_COUNT_BITS-1:0] corr_cnt_reg, corr_cnt_next;
    logic [FRAME_COUNT_BITS-1:0] unc_cnt_reg, unc_cnt_next;
    logic                        out_valid_reg, out_valid_next;
    hfd_result_t                 result_reg, result_next;

    logic [LEN_W-1:0]            room;
    logic [CNT_W-1:0]            take;
    logic [LEN_W-1:0]            delivered_sum;
    logic [FRAME_COUNT_BITS-1:0] corr_new;
    logic [FRAME_COUNT_BITS-1:0] unc_new;
    logic [WIDE_W-1:0]           corr_wide;
    logic [WIDE_W-1:0]           unc_wide;

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        room = (delivered_reg < original_length) ? original_length - delivered_reg : '0;
        take = (LEN_W'(head_item.count) < room) ? head_item.count : room[CNT_W-1:0];
        // take never exceeds room, so the sum stays within the length field
        delivered_sum = delivered_reg + LEN_W'(take);

        corr_new = (head_item.corrected && (corr_cnt_reg != '1))
                   ? corr_cnt_reg + FRAME_COUNT_BITS'(1) : corr_cnt_reg;
        unc_new  = (head_item.uncorrectable && (unc_cnt_reg != '1))
                   ? unc_cnt_reg + FRAME_COUNT_BITS'(1) : unc_cnt_reg;
        corr_wide = WIDE_W'(corr_new);
        unc_wide  = WIDE_W'(unc_new);

        result_next.data          = head_item.data & ~({DATA_W{1'b1}} << take);
        result_next.count         = take;
        result_next.syndrome      = head_item.syndrome;
        result_next.corrected     = head_item.corrected;
        result_next.uncorrectable = head_item.uncorrectable;
        result_next.frame_end     = head_item.last;
        result_next.frame_valid   = head_item.last && (delivered_sum >= original_length);
        result_next.corrected_blocks     = corr_wide[LEN_W-1:0];
        result_next.uncorrectable_blocks = unc_wide[LEN_W-1:0];

        delivered_next = delivered_reg;
        corr_cnt_next  = corr_cnt_reg;
        unc_cnt_next   = unc_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (head_item.last)
            begin
                delivered_next = '0;
                corr_cnt_next  = '0;
                unc_cnt_next   = '0;
            end
            else
            begin
                delivered_next = delivered_sum;
                corr_cnt_next  = corr_new;
                unc_cnt_next   = unc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delivered_reg <= '0;
            corr_cnt_reg  <= '0;
            unc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            delivered_reg <= delivered_next;
            corr_cnt_reg  <= corr_cnt_next;
            unc_cnt_reg   <= unc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_item.last |=> delivered_reg == '0 && corr_cnt_reg == '0
                                  && unc_cnt_reg == '0)
        else $error("frame state not cleared after last block");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.corrected && result_reg.uncorrectable))
        else $error("block marked both corrected and uncorrectable");

endmodule

// ===== verif/hamming_frame_decoder_tb.sv =====
// Self-checking testbench for hamming_frame_decoder: directed and random frames against a predictor.
module hamming_frame_decoder_tb;
    import hfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Block size clamp and counter ceiling used by the design under its defaults
    localparam int MAX_BLOCK      = 63;
    localparam int COUNT_MAX      = (1 << 20) - 1;
    // Index that no register answers to; writes to it must leave the settings alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // Receiver hold-off long enough to fill the internal queue many times over
    localparam int HOLDOFF_CYCLES = 200;
    // Quiet cycles after the last result
    localparam int DRAIN_TAIL     = 6;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int CYCLE_LIMIT    = 250000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DATA_BITS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [BLOCK_W-1:0]    block_bits = '0;
    logic                  last_block = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DATA_W-1:0]     data_out;
    logic [CNT_W-1:0]      data_count;
    logic [SYN_W-1:0]      syndrome;
    logic                  corrected;
    logic                  uncorrectable;
    logic                  frame_end;
    logic                  frame_valid;
    logic [LEN_W-1:0]      corrected_blocks;
    logic [LEN_W-1:0]      uncorrectable_blocks;

    // Predictor copy of the register settings and the frame bookkeeping
    int unsigned cfg_m = 4;
    int unsigned cfg_r = 3;
    int unsigned cfg_len = 0;
    int unsigned delivered_total = 0;
    int unsigned corrected_total = 0;
    int unsigned uncorrectable_total = 0;

    // Decoded results still owed by the block, oldest first
    hfd_result_t predicted_blocks[$];

    int          mismatches = 0;
    int          cycle_count = 0;
    int          random_sent = 0;
    int          burst_left = 0;
    int          gap_max = 0;
    stall_mode_t stall_mode = STALL_NONE;
    logic [7:0]  stall_pattern = 8'b0110_1001;
    bit          holdoff_start = 1'b0;
    int          holdoff_left = 0;

    hamming_frame_decoder DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .block_bits           (block_bits),
        .last_block           (last_block),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .data_out             (data_out),
        .data_count           (data_count),
        .syndrome             (syndrome),
        .corrected            (corrected),
        .uncorrectable        (uncorrectable),
        .frame_end            (frame_end),
        .frame_valid          (frame_valid),
        .corrected_blocks     (corrected_blocks),
        .uncorrectable_blocks (uncorrectable_blocks)
    );

    // 4 ns clock, high then low
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: abandon the run if the design stops moving transactions
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hamming_frame_decoder test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Helpers shared by the encoder and the predictor
    // ------------------------------------------------------------------

    function automatic logic [BLOCK_W-1:0] random_block();
        return BLOCK_W'({$urandom(), $urandom()});
    endfunction

    // Even parity over positions 1..n for each of the first r weights
    function automatic logic [SYN_W-1:0] parity_syndrome(logic [BLOCK_W-1:0] blk, int n, int r);
        logic [SYN_W-1:0] s;
        logic             par;
        s = '0;
        for (int k = 0; k < r && k < SYN_W; k++)
        begin
            par = 1'b0;
            for (int p = 1; p <= n; p++)
                if ((p & (1 << k)) != 0)
                    par ^= blk[p-1];
            s[k] = par;
        end
        return s;
    endfunction

    // Random content with the parity positions fixed up so the syndrome is zero.
    // Flipping position 2^k touches only syndrome bit k, so one pass suffices.
    function automatic logic [BLOCK_W-1:0] make_codeword(int n, int r);
        logic [BLOCK_W-1:0] blk;
        logic [SYN_W-1:0]   s;
        blk = random_block();
        s = parity_syndrome(blk, n, r);
        for (int k = 0; k < SYN_W; k++)
            if (s[k])
                blk[(1 << k) - 1] = ~blk[(1 << k) - 1];
        return blk;
    endfunction

    // Mostly clean or single-error blocks, some double errors and raw noise
    function automatic logic [BLOCK_W-1:0] make_test_block(int n, int r);
        logic [BLOCK_W-1:0] blk;
        int                 p1;
        int                 p2;
        blk = make_codeword(n, r);
        case ($urandom_range(0, 9))
            4, 5, 6, 7:
            begin
                p1 = $urandom_range(1, n);
                blk[p1-1] = ~blk[p1-1];
            end
            8:
            begin
                p1 = $urandom_range(1, n);
                p2 = $urandom_range(1, n - 1);
                if (p2 >= p1)
                    p2++;
                blk[p1-1] = ~blk[p1-1];
                blk[p2-1] = ~blk[p2-1];
            end
            9: blk = random_block();
            default: ;
        endcase
        return blk;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: decode one accepted block and queue the expected result
    // ------------------------------------------------------------------
    task automatic decode_block(input logic [BLOCK_W-1:0] raw, input logic lst);
        hfd_result_t        res;
        logic [BLOCK_W-1:0] blk;
        logic [SYN_W-1:0]   syn;
        logic [DATA_W-1:0]  data;
        int                 n;
        int                 cnt;
        int unsigned        room;
        int unsigned        take;
        n = cfg_m + cfg_r;
        if (n > MAX_BLOCK)
            n = MAX_BLOCK;
        blk = raw & BLOCK_W'((64'd1 << n) - 64'd1);
        syn = parity_syndrome(blk, n, cfg_r);
        res = '0;
        if (syn != '0)
        begin
            if (int'(syn) <= n)
            begin
                blk[int'(syn) - 1] = ~blk[int'(syn) - 1];
                res.corrected = 1'b1;
                if (corrected_total < COUNT_MAX)
                    corrected_total++;
            end
            else
            begin
                res.uncorrectable = 1'b1;
                if (uncorrectable_total < COUNT_MAX)
                    uncorrectable_total++;
            end
        end
        // Pack the non-power-of-two positions, lowest first
        data = '0;
        cnt = 0;
        for (int p = 1; p <= n; p++)
            if ((p & (p - 1)) != 0)
            begin
                data[cnt] = blk[p-1];
                cnt++;
            end
        // Truncate so the frame never overshoots its length
        room = (delivered_total < cfg_len) ? cfg_len - delivered_total : 0;
        take = (cnt < room) ? cnt : room;
        data &= DATA_W'((64'd1 << take) - 64'd1);
        delivered_total += take;
        res.data                 = data;
        res.count                = CNT_W'(take);
        res.syndrome             = syn;
        res.frame_end            = lst;
        res.frame_valid          = lst && (delivered_total >= cfg_len);
        res.corrected_blocks     = LEN_W'(corrected_total);
        res.uncorrectable_blocks = LEN_W'(uncorrectable_total);
        predicted_blocks = {predicted_blocks, res};
        if (lst)
        begin
            delivered_total = 0;
            corrected_total = 0;
            uncorrectable_total = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one block and hold it until the transaction completes. Called just
    // after a rising edge; idles between bursts when gaps are enabled.
    task automatic offer_block(input logic [BLOCK_W-1:0] blk, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0)
            begin
                gap = $urandom_range(0, gap_max);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        block_bits <= blk;
        last_block <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_block(blk, lst);
    endtask

    // Drop valid and wait until every queued result has been seen
    task automatic wait_frames_flushed();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Write all three registers (plus the unused index) while idle
    task automatic configure(input int m, input int r, input int len);
        cfg_write <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom());
        @(posedge clk);
        cfg_index <= REG_DATA_BITS;
        cfg_data  <= CFG_DATA_W'(m);
        @(posedge clk);
        cfg_index <= REG_PARITY_BITS;
        cfg_data  <= CFG_DATA_W'(r);
        @(posedge clk);
        cfg_index <= REG_ORIG_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_m   = m & 32'h3F;
        cfg_r   = r & 32'h7;
        cfg_len = len & 32'hFFFFF;
    endtask

    // ------------------------------------------------------------------
    // Output side: stall driver and result checker
    // ------------------------------------------------------------------

    // The receiver keeps its own stall pattern; a hold-off request overrides it
    always @(posedge clk)
    begin
        if (holdoff_start)
        begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_start = 1'b0;
        end
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                STALL_PATTERN:
                begin
                    out_stall <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                end
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // Print one line per mismatch (up to a cap) and count every one
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("cycle %0d: %s mismatch, got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
    endtask

    // Compare each completed output transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        hfd_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_blocks.size() == 0)
                report_mismatch("unexpected result, data_out", 64'(data_out), 64'd0);
            else
            begin
                want = predicted_blocks.pop_front();
                if (data_out !== want.data)
                    report_mismatch("data_out", 64'(data_out), 64'(want.data));
                if (data_count !== want.count)
                    report_mismatch("data_count", 64'(data_count), 64'(want.count));
                if (syndrome !== want.syndrome)
                    report_mismatch("syndrome", 64'(syndrome), 64'(want.syndrome));
                if (corrected !== want.corrected)
                    report_mismatch("corrected", 64'(corrected), 64'(want.corrected));
                if (uncorrectable !== want.uncorrectable)
                    report_mismatch("uncorrectable", 64'(uncorrectable),
                                    64'(want.uncorrectable));
                if (frame_end !== want.frame_end)
                    report_mismatch("frame_end", 64'(frame_end), 64'(want.frame_end));
                if (frame_valid !== want.frame_valid)
                    report_mismatch("frame_valid", 64'(frame_valid), 64'(want.frame_valid));
                if (corrected_blocks !== want.corrected_blocks)
                    report_mismatch("corrected_blocks", 64'(corrected_blocks),
                                    64'(want.corrected_blocks));
                if (uncorrectable_blocks !== want.uncorrectable_blocks)
                    report_mismatch("uncorrectable_blocks", 64'(uncorrectable_blocks),
                                    64'(want.uncorrectable_blocks));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (m=4, r=3, zero length): the frame is full from the start
    task automatic test_reset_values();
        gap_max = 0;
        stall_mode = STALL_NONE;
        offer_block(random_block(), 1'b0);
        offer_block(make_codeword(7, 3), 1'b0);
        offer_block(random_block(), 1'b1);
        wait_frames_flushed();
    endtask

    // Field extremes, every error class and each corner of the frame logic
    task automatic test_directed_cases();
        logic [BLOCK_W-1:0] cw;
        stall_mode = STALL_LIGHT;
        gap_max = 2;

        // Short frame that fills after two blocks; later blocks deliver nothing
        configure(4, 3, 8);
        offer_block('0, 1'b0);
        offer_block({BLOCK_W{1'b1}}, 1'b0);
        cw = make_codeword(7, 3);
        offer_block(cw ^ BLOCK_W'(1), 1'b0);
        offer_block(cw ^ BLOCK_W'(8), 1'b0);
        offer_block(cw ^ BLOCK_W'(64), 1'b0);
        offer_block(make_codeword(7, 3), 1'b1);
        wait_frames_flushed();

        // Syndrome 7 points past a six-position block; frame ends short
        configure(3, 3, 20);
        offer_block(BLOCK_W'(12) | (random_block() & ~BLOCK_W'(63)), 1'b0);
        offer_block(make_codeword(6, 3), 1'b1);
        wait_frames_flushed();

        // Widest block and largest length; errors on positions 63 and 32
        configure(57, 6, 20'hFFFFF);
        offer_block({BLOCK_W{1'b1}}, 1'b0);
        cw = make_codeword(63, 6);
        offer_block(cw ^ (BLOCK_W'(1) << 62), 1'b0);
        cw = make_codeword(63, 6);
        offer_block(cw ^ (BLOCK_W'(1) << 31), 1'b1);
        wait_frames_flushed();

        // Smallest block with a zero-length frame
        configure(1, 2, 0);
        offer_block(BLOCK_W'(7), 1'b1);
        offer_block(random_block(), 1'b1);
        wait_frames_flushed();

        // Oversized block: n clamps to the widest supported size
        configure(60, 6, 100);
        offer_block(random_block(), 1'b0);
        offer_block(random_block(), 1'b1);
        wait_frames_flushed();

        // Parity count larger than the block needs: upper weights see nothing
        configure(1, 6, 5);
        offer_block(random_block(), 1'b0);
        offer_block(random_block(), 1'b1);
        wait_frames_flushed();
    endtask

    // Hold the receiver off while the sender keeps offering back to back,
    // so the internal queue fills and the input stalls
    task automatic test_backpressure();
        configure(11, 4, 200);
        stall_mode = STALL_NONE;
        gap_max = 0;
        holdoff_start = 1'b1;
        for (int i = 0; i < 48; i++)
            offer_block(make_test_block(15, 4), (i % 8) == 7);
        wait_frames_flushed();
        // Second pass with a choppy receiver after the hold-off
        stall_mode = STALL_PATTERN;
        holdoff_start = 1'b1;
        for (int i = 0; i < 16; i++)
            offer_block(make_test_block(15, 4), i == 15);
        wait_frames_flushed();
    endtask

    // Phases of random settings, each carrying several well-formed frames
    task automatic test_random_frames();
        int m;
        int r;
        int n;
        int len;
        int frames;
        int blocks;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: m = 57;
                1: m = 1;
                default: m = $urandom_range(1, 57);
            endcase
            // Smallest consistent parity count, occasionally any legal one
            r = 2;
            while ((1 << r) < m + r + 1)
                r++;
            if ($urandom_range(0, 4) == 0)
                r = $urandom_range(2, 6);
            n = m + r;
            case ($urandom_range(0, 5))
                0: len = 0;
                1: len = 20'hFFFFF;
                default: len = $urandom_range(0, 10 * m);
            endcase
            configure(m, r, len);

            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: stall_mode = STALL_NONE;
                1: stall_mode = STALL_LIGHT;
                2: stall_mode = STALL_HEAVY;
                default: stall_mode = STALL_PATTERN;
            endcase
            stall_pattern = 8'($urandom());

            frames = $urandom_range(2, 6);
            for (int f = 0; f < frames; f++)
            begin
                blocks = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
                for (int b = 0; b < blocks; b++)
                begin
                    offer_block(make_test_block(n, r), b == blocks - 1);
                    random_sent++;
                end
            end
            wait_frames_flushed();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_cases();
        test_backpressure();
        test_random_frames();

        wait_frames_flushed();
        if (mismatches == 0 && predicted_blocks.size() == 0)
            $display("hamming_frame_decoder test passed");
        else
            $display("hamming_frame_decoder test failed");
        $finish;
    end

endmodule
